// ===== rtl/core/adpcm_pkg.sv =====
package adpcm_pkg;

  // queue between front and back, depth must be a power of two
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

  // configuration register indexes
  localparam logic [2:0] CfgCoefPairs01  = 3'd0;
  localparam logic [2:0] CfgCoefPairs23  = 3'd1;
  localparam logic [2:0] CfgCoefPairs45  = 3'd2;
  localparam logic [2:0] CfgCoefPairs67  = 3'd3;
  localparam logic [2:0] CfgInitHistOne  = 3'd4;
  localparam logic [2:0] CfgInitHistTwo  = 3'd5;

  localparam int unsigned CoefRegCount = 4;

  typedef enum logic [1:0] {
    OpReload,
    OpError,
    OpData
  } op_kind_e;

  // one classified byte handed from front to back
  typedef struct packed {
    op_kind_e   kind;
    logic [7:0] data_byte;
    logic       high_only;
    logic [3:0] shift;
    logic [2:0] pair;
  } op_t;

  typedef struct packed {
    logic [CoefRegCount-1:0][63:0] coef;
    logic signed [15:0]            init_h1;
    logic signed [15:0]            init_h2;
  } cfg_t;

endpackage

// ===== rtl/core/adpcm_front.sv =====
module adpcm_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  logic [7:0]     data_byte_i,
  input  logic           start_of_stream_i,
  input  logic           high_nibble_only_i,
  output logic           push_o,
  output adpcm_pkg::op_t op_o
);

  logic [2:0] byte_in_frame_q, byte_in_frame_d;
  logic [3:0] shift_q, shift_d;
  logic [2:0] pair_q, pair_d;
  logic       stopped_q, stopped_d;

  always_comb begin
    logic       stopped_eff;
    logic [2:0] bif_eff;
    stopped_eff     = stopped_q & ~start_of_stream_i;
    bif_eff         = start_of_stream_i ? 3'd0 : byte_in_frame_q;
    byte_in_frame_d = byte_in_frame_q;
    shift_d         = shift_q;
    pair_d          = pair_q;
    stopped_d       = stopped_q;
    push_o          = 1'b0;
    op_o.kind       = adpcm_pkg::OpData;
    op_o.data_byte  = data_byte_i;
    op_o.high_only  = high_nibble_only_i;
    op_o.shift      = shift_q;
    op_o.pair       = pair_q;
    if (accept_i) begin
      stopped_d       = stopped_eff;
      byte_in_frame_d = bif_eff;
      if (!stopped_eff) begin
        if (bif_eff == 3'd0) begin
          if (data_byte_i[7]) begin
            // pair index 8 or more
            stopped_d = 1'b1;
            push_o    = 1'b1;
            op_o.kind = adpcm_pkg::OpError;
          end else begin
            shift_d         = data_byte_i[3:0];
            pair_d          = data_byte_i[6:4];
            byte_in_frame_d = 3'd1;
            push_o          = start_of_stream_i;
            op_o.kind       = adpcm_pkg::OpReload;
          end
        end else begin
          push_o          = 1'b1;
          op_o.kind       = adpcm_pkg::OpData;
          byte_in_frame_d = bif_eff + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_in_frame_q <= 3'd0;
      shift_q         <= 4'd0;
      pair_q          <= 3'd0;
      stopped_q       <= 1'b0;
    end else begin
      byte_in_frame_q <= byte_in_frame_d;
      shift_q         <= shift_d;
      pair_q          <= pair_d;
      stopped_q       <= stopped_d;
    end
  end

endmodule

// ===== rtl/core/adpcm_queue.sv =====
module adpcm_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  adpcm_pkg::op_t op_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           empty_o,
  output adpcm_pkg::op_t head_o
);

  adpcm_pkg::op_t                     mem_q [adpcm_pkg::QueueDepth];
  logic [adpcm_pkg::QueuePtrW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [adpcm_pkg::QueuePtrW:0]      count_q, count_d;

  assign full_o  = (count_q == (adpcm_pkg::QueuePtrW + 1)'(adpcm_pkg::QueueDepth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) count_d = count_q + 1'b1;
    if (pop_i && !push_i) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i) rd_ptr_q <= rd_ptr_q + 1'b1;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= op_i;
  end

endmodule

// ===== rtl/core/adpcm_back.sv =====
module adpcm_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  adpcm_pkg::cfg_t cfg_i,
  input  logic            empty_i,
  input  adpcm_pkg::op_t  head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [15:0]     sample_o,
  output logic            bad_header_o,
  output logic            last_of_run_o
);

  logic               phase_q, phase_d;
  logic signed [15:0] h1_q, h1_d, h2_q, h2_d;
  logic               out_valid_q, out_valid_d;
  logic [15:0]        sample_q, sample_d;
  logic               bad_q, bad_d;
  logic               last_q, last_d;

  logic               can_emit;
  logic [63:0]        coef_reg;
  logic signed [15:0] c1, c2;
  logic [3:0]         nib;
  logic signed [33:0] term;
  logic signed [31:0] p1, p2;
  logic signed [33:0] acc;
  logic signed [22:0] shr;
  logic signed [15:0] clamped;

  assign can_emit = !out_valid_q || !out_stall_i;

  // sample datapath, one sample per cycle while the output is not stalled
  always_comb begin
    coef_reg = cfg_i.coef[head_i.pair[2:1]];
    c1       = head_i.pair[0] ? coef_reg[31:16] : coef_reg[63:48];
    c2       = head_i.pair[0] ? coef_reg[15:0]  : coef_reg[47:32];
    nib      = phase_q ? head_i.data_byte[3:0] : head_i.data_byte[7:4];
    term     = $signed({{30{nib[3]}}, nib}) <<< ({1'b0, head_i.shift} + 5'd11);
    p1       = c1 * h1_q;
    p2       = c2 * h2_q;
    acc      = term + 34'(p1) + 34'(p2) + 34'sd1024;
    shr      = acc[33:11];
    if (shr > 23'sd32767) clamped = 16'sh7fff;
    else if (shr < -23'sd32768) clamped = 16'sh8000;
    else clamped = shr[15:0];
  end

  always_comb begin
    phase_d     = phase_q;
    h1_d        = h1_q;
    h2_d        = h2_q;
    out_valid_d = out_valid_q & out_stall_i;
    sample_d    = sample_q;
    bad_d       = bad_q;
    last_d      = last_q;
    pop_o       = 1'b0;
    if (!empty_i) begin
      unique case (head_i.kind)
        adpcm_pkg::OpReload: begin
          h1_d  = cfg_i.init_h1;
          h2_d  = cfg_i.init_h2;
          pop_o = 1'b1;
        end
        adpcm_pkg::OpError: begin
          if (can_emit) begin
            out_valid_d = 1'b1;
            sample_d    = 16'd0;
            bad_d       = 1'b1;
            last_d      = 1'b1;
            pop_o       = 1'b1;
          end
        end
        adpcm_pkg::OpData: begin
          if (can_emit) begin
            out_valid_d = 1'b1;
            sample_d    = clamped;
            bad_d       = 1'b0;
            last_d      = phase_q | head_i.high_only;
            h2_d        = h1_q;
            h1_d        = clamped;
            pop_o       = last_d;
            phase_d     = ~last_d;
          end
        end
        default: begin
          pop_o = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= 1'b0;
      h1_q        <= '0;
      h2_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      h1_q        <= h1_d;
      h2_q        <= h2_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q <= sample_d;
    bad_q    <= bad_d;
    last_q   <= last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign sample_o      = sample_q;
  assign bad_header_o  = bad_q;
  assign last_of_run_o = last_q;

endmodule

// ===== rtl/core/dsp_adpcm_decoder_unit.sv =====
// dsp adpcm 4-bit decoder: one stream byte per input transaction, frames of a header
// byte and seven data bytes; each data byte gives two 16-bit samples (one if
// high_nibble_only_i is set), a header with pair index 8 or more gives one error
// result and mutes the stream until the next start_of_stream_i. the front classifies
// a byte in the cycle it is accepted and hands it through a 4-entry queue to the back,
// which makes one sample per cycle while the output is not stalled, through two 16x16
// multipliers and a 34-bit sum that also carries the history feedback. a header
// reaches the back only when it carries start_of_stream_i (history reload) or is
// bad (error result); other headers never reach it. with an empty queue and a free
// output register, the first sample of a byte passes through the queue into the
// output register, and the second one follows at the edge that pops the byte.
// the input stalls only while the queue is full. config writes are always ready
// and are meant for idle periods only; there is no clearing pass after reset.
module dsp_adpcm_decoder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        start_of_stream_i,
  input  logic        high_nibble_only_i,
  // result stream
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [15:0] sample_o,
  output logic        bad_header_o,
  output logic        last_of_run_o,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  adpcm_pkg::cfg_t cfg_q;
  adpcm_pkg::op_t  push_op;
  adpcm_pkg::op_t  head_op;
  logic            in_accept;
  logic            push;
  logic            pop;
  logic            q_full;
  logic            q_empty;
  logic [15:0]     sample_raw;

  // config registers, writes land in the next cycle
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        adpcm_pkg::CfgCoefPairs01: cfg_q.coef[0] <= cfg_data_i;
        adpcm_pkg::CfgCoefPairs23: cfg_q.coef[1] <= cfg_data_i;
        adpcm_pkg::CfgCoefPairs45: cfg_q.coef[2] <= cfg_data_i;
        adpcm_pkg::CfgCoefPairs67: cfg_q.coef[3] <= cfg_data_i;
        adpcm_pkg::CfgInitHistOne: cfg_q.init_h1 <= cfg_data_i[15:0];
        adpcm_pkg::CfgInitHistTwo: cfg_q.init_h2 <= cfg_data_i[15:0];
        default: begin
          // unknown index, write dropped
        end
      endcase
    end
  end

  // stall only on a full queue, a registered condition
  assign in_stall_o = q_full;
  assign in_accept  = in_valid_i && !in_stall_o;

  // front: frame position, header fields, stopped flag
  adpcm_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .accept_i           (in_accept),
    .data_byte_i        (data_byte_i),
    .start_of_stream_i  (start_of_stream_i),
    .high_nibble_only_i (high_nibble_only_i),
    .push_o             (push),
    .op_o               (push_op)
  );

  // decouples the byte rate from the sample rate
  adpcm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (push_op),
    .pop_i   (pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .head_o  (head_op)
  );

  // back: history, predictor arithmetic and output register
  adpcm_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .empty_i       (q_empty),
    .head_i        (head_op),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .sample_o      (sample_raw),
    .bad_header_o  (bad_header_o),
    .last_of_run_o (last_of_run_o)
  );

  assign sample_o = $signed(sample_raw);

endmodule

// ===== tb/adpcm_check_pkg.sv =====
`timescale 1ns / 1ps

package adpcm_check_pkg;

  import adpcm_pkg::*;

  typedef struct {
    logic signed [15:0] sample;
    logic               bad_header;
    logic               last_of_run;
  } adpcm_result_t;

  // tracks decoder state and the samples it is expected to produce
  class adpcm_decode_tracker;
    localparam int unsigned MaxReports = 100;

    logic [63:0]        coef_word [CoefRegCount];
    logic signed [15:0] start_h1;
    logic signed [15:0] start_h2;

    logic [2:0]         frame_pos;
    logic signed [15:0] hist1;
    logic signed [15:0] hist2;
    logic [3:0]         shift_amt;
    logic [2:0]         pair_idx;
    bit                 muted;

    adpcm_result_t      pending_samples [$];
    int unsigned        fail_count;
    int unsigned        reported;

    function new();
      foreach (coef_word[i]) coef_word[i] = '0;
      start_h1   = '0;
      start_h2   = '0;
      frame_pos  = '0;
      hist1      = '0;
      hist2      = '0;
      shift_amt  = '0;
      pair_idx   = '0;
      muted      = 1'b0;
      fail_count = 0;
      reported   = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [63:0] data);
      case (idx)
        CfgCoefPairs01: coef_word[0] = data;
        CfgCoefPairs23: coef_word[1] = data;
        CfgCoefPairs45: coef_word[2] = data;
        CfgCoefPairs67: coef_word[3] = data;
        CfgInitHistOne: start_h1 = data[15:0];
        CfgInitHistTwo: start_h2 = data[15:0];
        default: ;
      endcase
    endfunction

    function logic signed [15:0] coef(bit second);
      logic [63:0] w;
      int          pos;
      w   = coef_word[pair_idx[2:1]];
      pos = int'(pair_idx[0]) * 2 + int'(second);
      return w[63 - 16 * pos -: 16];
    endfunction

    // one predicted sample, history shifts afterwards
    function logic signed [15:0] next_sample(logic [3:0] code);
      logic signed [3:0] n;
      longint            acc;
      n   = code;
      acc = (longint'(n) <<< shift_amt) * 2048
          + longint'(coef(1'b0)) * longint'(hist1)
          + longint'(coef(1'b1)) * longint'(hist2)
          + 1024;
      acc = acc >>> 11;
      if (acc < -32768) acc = -32768;
      if (acc > 32767) acc = 32767;
      hist2 = hist1;
      hist1 = acc[15:0];
      return hist1;
    endfunction

    function void push(logic signed [15:0] s, logic bad, logic last);
      adpcm_result_t r;
      r.sample      = s;
      r.bad_header  = bad;
      r.last_of_run = last;
      pending_samples.push_back(r);
    endfunction

    function void note_byte(logic [7:0] b, logic sos, logic hno);
      logic signed [15:0] s;
      if (sos) begin
        muted     = 1'b0;
        frame_pos = '0;
        hist1     = start_h1;
        hist2     = start_h2;
      end
      if (muted) return;
      if (frame_pos == 0) begin
        if (b[7]) begin
          muted = 1'b1;
          push('0, 1'b1, 1'b1);
          return;
        end
        shift_amt = b[3:0];
        pair_idx  = b[6:4];
        frame_pos = 3'd1;
        return;
      end
      s = next_sample(b[7:4]);
      push(s, 1'b0, hno);
      if (!hno) begin
        s = next_sample(b[3:0]);
        push(s, 1'b0, 1'b1);
      end
      frame_pos = frame_pos + 3'd1;
    endfunction

    function void report(string field, longint want, longint got);
      fail_count++;
      if (reported < MaxReports) begin
        reported++;
        $error("%s mismatch: expected %0d, actual %0d", field, want, got);
      end
    endfunction

    function void check_sample(logic signed [15:0] s, logic bad, logic last);
      adpcm_result_t want;
      if (pending_samples.size() == 0) begin
        fail_count++;
        if (reported < MaxReports) begin
          reported++;
          $error("result with nothing expected: sample %0d bad_header %0b", s, bad);
        end
        return;
      end
      want = pending_samples.pop_front();
      if (s !== want.sample) report("sample", want.sample, s);
      if (bad !== want.bad_header) report("bad_header", want.bad_header, bad);
      if (last !== want.last_of_run) report("last_of_run", want.last_of_run, last);
    endfunction

    function int pending();
      return pending_samples.size();
    endfunction
  endclass

endpackage

// ===== tb/dsp_adpcm_decoder_unit_test.sv =====
`timescale 1ns / 1ps

module dsp_adpcm_decoder_unit_test;

  import adpcm_pkg::*;
  import adpcm_check_pkg::*;

  // indexes the block has no register for, writes there must be ignored
  localparam logic [2:0] CfgUnusedLo = 3'd6;
  localparam logic [2:0] CfgUnusedHi = 3'd7;

  localparam int unsigned SettleCycles  = 24;   // queue depth plus pipeline, with margin
  localparam int unsigned HoldCycles    = 300;  // long receiver hold-off
  localparam int unsigned PhaseBytes    = 135;
  localparam int unsigned PhaseCount    = 6;
  localparam int unsigned DrainLimit    = 20000;

  logic        clk_i;
  logic        rst_ni             = 1'b0;
  logic        in_valid_i         = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i        = '0;
  logic        start_of_stream_i  = 1'b0;
  logic        high_nibble_only_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i        = 1'b0;
  logic signed [15:0] sample_o;
  logic        bad_header_o;
  logic        last_of_run_o;
  logic        cfg_valid_i        = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i        = '0;
  logic [63:0] cfg_data_i         = '0;

  adpcm_decode_tracker tracker = new();

  bit          idle_on     = 1'b0;  // random gaps on both sides
  bit          hold_req    = 1'b0;  // asks the result side for one long hold-off
  bit          need_start  = 1'b1;  // next frame must carry start_of_stream
  int unsigned stream_bytes = 0;

  dsp_adpcm_decoder_unit uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .data_byte_i        (data_byte_i),
    .start_of_stream_i  (start_of_stream_i),
    .high_nibble_only_i (high_nibble_only_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .sample_o           (sample_o),
    .bad_header_o       (bad_header_o),
    .last_of_run_o      (last_of_run_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // overall limit, far above the slowest legal run
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // one input transaction; valid stays high afterwards so the next byte can follow
  // back to back, callers close a burst with end_burst
  task automatic send_byte(input logic [7:0] value, input logic sos, input logic hno);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_valid_i         <= 1'b1;
    data_byte_i        <= value;
    start_of_stream_i  <= sos;
    high_nibble_only_i <= hno;
    // outputs read right after the edge still hold their pre-edge values
    do @(posedge clk_i); while (in_stall_o);
    tracker.note_byte(value, sos, hno);
    stream_bytes++;
  endtask

  task automatic end_burst();
    in_valid_i <= 1'b0;
  endtask

  // wait until every expected sample is out, then give bytes without results time
  // to leave the queue before touching the registers
  task automatic settle();
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic put_reg(input logic [2:0] idx, input logic [63:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.set_reg(idx, data);
  endtask

  task automatic program_regs(input logic [63:0] c01, input logic [63:0] c23,
                              input logic [63:0] c45, input logic [63:0] c67,
                              input logic [15:0] h1, input logic [15:0] h2);
    put_reg(CfgCoefPairs01, c01);
    put_reg(CfgCoefPairs23, c23);
    put_reg(CfgCoefPairs45, c45);
    put_reg(CfgCoefPairs67, c67);
    put_reg(CfgInitHistOne, {{48{$urandom_range(0, 1) == 1}}, h1});
    put_reg(CfgInitHistTwo, {48'($urandom), h2});
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // four signed coefficients, each within +-mag
  function automatic logic [63:0] coef_word_rand(int unsigned mag);
    logic [63:0] w;
    int          v;
    for (int i = 0; i < 4; i++) begin
      v = int'($urandom_range(0, 2 * mag - 1)) - int'(mag);
      w[16 * i +: 16] = 16'(v);
    end
    return w;
  endfunction

  // mostly well-formed frames with random content; some bad headers, cut frames
  // and stray bytes mixed in
  task automatic send_frame();
    int          roll;
    int          ndata;
    logic [7:0]  hdr;
    logic        sos;
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      repeat ($urandom_range(1, 4))
        send_byte(8'($urandom), 1'($urandom), 1'($urandom));
      need_start = 1'b1;
      return;
    end
    sos = need_start || ($urandom_range(0, 1) == 0);
    need_start = 1'b0;
    hdr = {1'b0, 3'($urandom_range(0, 7)), 4'($urandom)};
    if (roll < 16) hdr[7] = 1'b1;
    send_byte(hdr, sos, 1'($urandom));
    if (hdr[7]) begin
      // stream is muted now, these bytes must be dropped
      repeat ($urandom_range(0, 3)) send_byte(8'($urandom), 1'b0, 1'($urandom));
      need_start = 1'b1;
      return;
    end
    ndata = 7;
    if ($urandom_range(0, 7) == 0) begin
      ndata = $urandom_range(0, 6);
      need_start = 1'b1;
    end
    for (int i = 0; i < ndata; i++)
      send_byte(8'($urandom), 1'b0, $urandom_range(0, 9) == 0);
  endtask

  // result side: check each accepted result, stall in random bursts or one long hold
  initial begin : result_sink
    int unsigned stall_left;
    logic        stall_next;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i)
        tracker.check_sample(sample_o, bad_header_o, last_of_run_o);
      if (stall_left == 0 && hold_req) begin
        stall_left = HoldCycles;
        hold_req   = 1'b0;
      end else if (stall_left == 0 && idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 15);
      end
      stall_next = (stall_left != 0);
      if (stall_left != 0) stall_left--;
      out_stall_i <= stall_next;
    end
  end

  initial begin : stimulus
    int unsigned target;
    int unsigned waited;
    int          style;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    idle_on = 1'b1;

    // bytes before any start decode from the reset state, zero coefficients
    send_byte(8'h03, 1'b0, 1'b0);
    send_byte(8'h87, 1'b0, 1'b0);
    send_byte(8'h0F, 1'b0, 1'b1);
    end_burst();
    settle();

    // extreme coefficients; writes to unknown indexes must change nothing
    put_reg(CfgUnusedLo, '1);
    program_regs({16'h7FFF, 16'h8000, 16'h0800, 16'hFC00},
                 coef_word_rand(4096), coef_word_rand(32768),
                 {16'h1000, 16'h0000, 16'h8000, 16'h8000},
                 16'h7FFF, 16'h8000);
    put_reg(CfgUnusedHi, '1);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);

    // pair 0 at a large shift, nibble extremes
    send_byte(8'h0C, 1'b1, 1'b0);
    send_byte(8'h7F, 1'b0, 1'b0);
    send_byte(8'h80, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    // restart mid-frame, pair 7 at the largest shift, full frame with a partial byte
    send_byte(8'h7F, 1'b1, 1'b0);
    send_byte(8'h77, 1'b0, 1'b0);
    send_byte(8'h88, 1'b0, 1'b0);
    send_byte(8'h12, 1'b0, 1'b0);
    send_byte(8'h34, 1'b0, 1'b0);
    send_byte(8'h56, 1'b0, 1'b1);
    send_byte(8'h9A, 1'b0, 1'b0);
    send_byte(8'hE1, 1'b0, 1'b0);
    // next frame header without a start, history carries over
    send_byte(8'h25, 1'b0, 1'b0);
    send_byte(8'hC3, 1'b0, 1'b0);
    // bad header mutes the stream until the next start
    send_byte(8'h80, 1'b1, 1'b0);
    send_byte(8'hF0, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b1);
    send_byte(8'hF5, 1'b1, 1'b1);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h40, 1'b1, 1'b1);
    send_byte(8'hA5, 1'b0, 1'b1);
    end_burst();
    need_start = 1'b1;

    for (int phase = 0; phase < PhaseCount; phase++) begin
      settle();
      style = phase % 5;
      case (style)
        0: program_regs(coef_word_rand(32768), coef_word_rand(32768),
                        coef_word_rand(32768), coef_word_rand(32768),
                        16'($urandom), 16'($urandom));
        1: program_regs({4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}},
                        16'h7FFF, 16'h7FFF);
        2: program_regs({4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}},
                        16'h8000, 16'h8000);
        3: program_regs(coef_word_rand(4096), coef_word_rand(4096),
                        coef_word_rand(4096), coef_word_rand(4096),
                        16'($urandom_range(0, 2047)), 16'($urandom_range(0, 2047)));
        default: program_regs('0, '0, '0, '0, '0, '0);
      endcase
      // last phase runs without any idling
      if (phase == PhaseCount - 1) idle_on = 1'b0;
      // block must fill up and stall its input while results are held off
      if (phase == 2) hold_req = 1'b1;
      need_start = 1'b1;
      target = stream_bytes + PhaseBytes;
      while (stream_bytes < target) send_frame();
      end_burst();
    end

    waited = 0;
    while (tracker.pending() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SettleCycles) @(posedge clk_i);
    if (tracker.pending() != 0) begin
      $error("%0d expected results never arrived", tracker.pending());
      tracker.fail_count++;
    end
    if (tracker.fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== dsp_adpcm_decoder_unit.f =====
rtl/core/adpcm_pkg.sv
rtl/core/adpcm_front.sv
rtl/core/adpcm_queue.sv
rtl/core/adpcm_back.sv
rtl/core/dsp_adpcm_decoder_unit.sv
tb/adpcm_check_pkg.sv
tb/dsp_adpcm_decoder_unit_test.sv
